>>> rtl/sslt_pkg.sv
// Shared types and constants for the sequence slot lease table.
// Used by sslt_time_cmp and sequence_slot_lease_table_core; no dependencies.
`default_nettype none

package sslt_pkg;

    localparam int SLOTS = 16;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam logic [31:0] NONE_OWNER = 32'hFFFF_FFFF;
    localparam logic [31:0] TIMEOUT_RESET = 32'd30000;
    localparam logic [4:0] ACTIVE_RESET = 5'd16;

    typedef enum logic [0:0] {
        REG_IDLE_TIMEOUT = 1'b0,
        REG_ACTIVE_SLOTS = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        FN_ACQUIRE  = 4'd0,
        FN_RELEASE  = 4'd1,
        FN_RETIRE   = 4'd2,
        FN_REL_LEASE = 4'd3,
        FN_COMPLETE = 4'd4,
        FN_REAP     = 4'd5,
        FN_EVICT    = 4'd6,
        FN_MARK     = 4'd7,
        FN_TOKENS   = 4'd8,
        FN_READ     = 4'd9,
        FN_LIVE     = 4'd10,
        FN_COUNTS   = 4'd11,
        FN_RSVD12   = 4'd12,
        FN_RSVD13   = 4'd13,
        FN_RSVD14   = 4'd14,
        FN_RSVD15   = 4'd15
    } func_t;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_PREFILL = 3'd1;
    localparam logic [2:0] PH_DECODE  = 3'd2;
    localparam logic [2:0] PH_RETIRE  = 3'd3;
    localparam logic [2:0] PH_DONE    = 3'd4;
    localparam logic [2:0] PH_EVICT   = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_SLOT = 3'd1;
    localparam logic [2:0] ST_NO_FREE  = 3'd2;
    localparam logic [2:0] ST_REJECT   = 3'd3;
    localparam logic [2:0] ST_NONE_EV  = 3'd4;

    typedef struct packed {
        logic [2:0]  phase;
        logic [31:0] owner;
        logic [31:0] gen;
        logic [19:0] tok;
        logic [31:0] access_time;
        logic [31:0] ready_time;
    } slot_entry_t;

    typedef struct packed {
        logic fence_passed;
        logic expired;
    } time_flags_t;

endpackage

`default_nettype wire

>>> rtl/sequence_slot_lease_table_core.sv
// Top level of the sequence slot lease table: sequencer, slot table, result register.
// Depends on sslt_pkg and sslt_time_cmp.
//
//  Channel | Handshake          | Beat contents
//  in      | in_valid/in_ready  | func, slot, requester, lease_generation, times, tokens
//  out     | out_valid/out_ready| status, slot fields, three counts, last
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// An item walks the table one slot a cycle through a single time comparator. Acquire
// reaps, scans for eviction and a free slot, writes the found slot and takes a phase
// census; reap reaps and takes the census; a release_lease that retires its slot writes
// it, reaps and takes the census; other operations act on one slot and take the census;
// evict scans, takes the census, then walks its mask for one beat per evicted slot;
// every beat waits until taken. Reset clears the table at once; writing active_slots
// reinitialises it likewise. in_ready and cfg_ready are high only when no item is in
// flight; a pending register write holds in_ready low.
`default_nettype none

module sequence_slot_lease_table_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [3:0]  func,
    input  wire logic [7:0]  slot,
    input  wire logic [31:0] requester,
    input  wire logic [31:0] lease_generation,
    input  wire logic [31:0] now_time,
    input  wire logic [31:0] ready_time,
    input  wire logic [31:0] timeout_arg,
    input  wire logic [19:0] token_value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [7:0]       slot_index,
    output logic [31:0]      generation,
    output logic [31:0]      owner_request,
    output logic [2:0]       phase,
    output logic [19:0]      tokens,
    output logic [4:0]       free_count,
    output logic [4:0]       used_count,
    output logic [4:0]       retiring_count,
    output logic             last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import sslt_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_REAP   = 7'b0000010,
        S_EVSCAN = 7'b0000100,
        S_OP     = 7'b0001000,
        S_COUNT  = 7'b0010000,
        S_EMIT   = 7'b0100000,
        S_WAIT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    slot_entry_t tbl_reg [SLOTS];

    logic [31:0] timeout_reg;
    logic [4:0]  active_reg;

    func_t       func_reg, func_next;
    logic [7:0]  slot_reg, slot_next;
    logic [31:0] req_reg, req_next;
    logic [31:0] lgen_reg, lgen_next;
    logic [31:0] now_reg, now_next;
    logic [31:0] rdy_reg, rdy_next;
    logic [31:0] tmo_reg, tmo_next;
    logic [19:0] tokv_reg, tokv_next;

    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] found_reg, found_next;
    logic             found_v_reg, found_v_next;
    logic [SLOTS-1:0] mask_reg, mask_next;
    logic             ev_emit_reg, ev_emit_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] fr_reg, fr_next;
    logic [CNT_W-1:0] us_reg, us_next;
    logic [CNT_W-1:0] rt_reg, rt_next;
    logic [2:0]       st_reg, st_next;
    logic             use_reg, use_next;
    logic [7:0]       ridx_reg, ridx_next;

    logic        ov_reg, ov_next;
    logic [2:0]  o_status_reg, o_status_next;
    logic [7:0]  o_idx_reg, o_idx_next;
    logic [31:0] o_gen_reg, o_gen_next;
    logic [31:0] o_own_reg, o_own_next;
    logic [2:0]  o_ph_reg, o_ph_next;
    logic [19:0] o_tok_reg, o_tok_next;
    logic [4:0]  o_fr_reg, o_fr_next;
    logic [4:0]  o_us_reg, o_us_next;
    logic [4:0]  o_rt_reg, o_rt_next;
    logic        o_last_reg, o_last_next;

    logic [CNT_W-1:0] n_live;
    logic             scan_end;
    logic             slot_ok;
    logic [IDX_W-1:0] rd_addr;
    slot_entry_t      ent, new_ent;
    logic             wr_en;
    logic [31:0]      cmp_stamp, cmp_limit;
    time_flags_t      tflags;
    logic             in_fire, cfg_fire;
    logic             ev_now, free_now;
    logic [CNT_W-1:0] cnt_fin;
    logic [SLOTS-1:0] mask_fin, mask_rest;

    // Handshakes; a pending register write goes ahead of an input beat.
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign in_fire   = in_valid & in_ready;
    assign cfg_fire  = cfg_valid & cfg_ready;

    // Active slot count, clamped to the table size and never zero.
    always_comb
    begin
        if (active_reg == 5'd0)
            n_live = CNT_W'(1);
        else if (32'(active_reg) > SLOTS)
            n_live = CNT_W'(SLOTS);
        else
            n_live = CNT_W'(active_reg);
    end

    assign scan_end = ({1'b0, i_reg} == (n_live - CNT_W'(1)));
    assign slot_ok  = ({3'b000, slot_reg} < 11'(n_live));

    // Single read port of the slot table.
    always_comb
    begin
        unique case (state_reg)
            S_OP:    rd_addr = (func_reg == FN_ACQUIRE) ? found_reg : slot_reg[IDX_W-1:0];
            S_EMIT:  rd_addr = ev_emit_reg ? i_reg : ridx_reg[IDX_W-1:0];
            default: rd_addr = i_reg;
        endcase
    end
    assign ent = tbl_reg[rd_addr];

    // The shared comparator looks at the fence time during reaping and at
    // the last access otherwise.
    assign cmp_stamp = (state_reg == S_REAP) ? ent.ready_time : ent.access_time;
    assign cmp_limit = (func_reg == FN_ACQUIRE) ? timeout_reg : tmo_reg;

    sslt_time_cmp u_time_cmp (
        .now_time (now_reg),
        .stamp    (cmp_stamp),
        .limit    (cmp_limit),
        .flags    (tflags)
    );

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        func_next = func_reg; slot_next = slot_reg; req_next = req_reg;
        lgen_next = lgen_reg; now_next = now_reg; rdy_next = rdy_reg;
        tmo_next = tmo_reg; tokv_next = tokv_reg;
        i_next = i_reg; found_next = found_reg; found_v_next = found_v_reg;
        mask_next = mask_reg; ev_emit_next = ev_emit_reg; cnt_next = cnt_reg;
        fr_next = fr_reg; us_next = us_reg; rt_next = rt_reg;
        st_next = st_reg; use_next = use_reg; ridx_next = ridx_reg;
        ov_next = ov_reg; o_status_next = o_status_reg; o_idx_next = o_idx_reg;
        o_gen_next = o_gen_reg; o_own_next = o_own_reg; o_ph_next = o_ph_reg;
        o_tok_next = o_tok_reg; o_fr_next = o_fr_reg; o_us_next = o_us_reg;
        o_rt_next = o_rt_reg; o_last_next = o_last_reg;
        new_ent = ent;
        wr_en = 1'b0;
        ev_now = 1'b0;
        free_now = 1'b0;
        cnt_fin = cnt_reg;
        mask_fin = mask_reg;
        mask_rest = mask_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    func_next = func_t'(func); slot_next = slot; req_next = requester;
                    lgen_next = lease_generation; now_next = now_time;
                    rdy_next = ready_time; tmo_next = timeout_arg; tokv_next = token_value;
                    i_next = '0; found_v_next = 1'b0; found_next = '0;
                    mask_next = '0; ev_emit_next = 1'b0; cnt_next = '0;
                    fr_next = '0; us_next = '0; rt_next = '0;
                    if (func_t'(func) == FN_ACQUIRE || func_t'(func) == FN_REAP)
                        state_next = S_REAP;
                    else if (func_t'(func) == FN_EVICT)
                        state_next = S_EVSCAN;
                    else
                        state_next = S_OP;
                end
            end

            // Reap retiring slots whose fence has passed, one slot a cycle.
            S_REAP:
            begin
                if (ent.phase == PH_RETIRE && tflags.fence_passed)
                begin
                    new_ent.phase = PH_IDLE;
                    new_ent.owner = NONE_OWNER;
                    new_ent.tok = '0;
                    new_ent.ready_time = '0;
                    wr_en = 1'b1;
                    cnt_fin = cnt_reg + CNT_W'(1);
                end
                cnt_next = cnt_fin;
                if (scan_end)
                begin
                    i_next = '0;
                    if (func_reg == FN_ACQUIRE)
                        state_next = S_EVSCAN;
                    else
                    begin
                        if (func_reg == FN_REL_LEASE)
                            st_next = (cnt_fin != '0) ? ST_OK : ST_REJECT;
                        else
                        begin
                            st_next = ST_OK; use_next = 1'b0; ridx_next = '0;
                        end
                        state_next = S_COUNT;
                    end
                end
                else
                    i_next = i_reg + IDX_W'(1);
            end

            // Evict stale decoding slots; acquire also notes the lowest free slot.
            S_EVSCAN:
            begin
                ev_now = (ent.phase == PH_DECODE) && tflags.expired;
                if (ev_now)
                begin
                    new_ent.phase = PH_EVICT;
                    wr_en = 1'b1;
                    mask_fin = mask_reg | (SLOTS'(1) << i_reg);
                end
                mask_next = mask_fin;
                free_now = ev_now || ent.phase == PH_IDLE || ent.phase == PH_EVICT;
                if (func_reg == FN_ACQUIRE && free_now && !found_v_reg)
                begin
                    found_next = i_reg;
                    found_v_next = 1'b1;
                end
                if (scan_end)
                begin
                    i_next = '0;
                    if (func_reg == FN_ACQUIRE)
                    begin
                        if (found_v_reg || free_now)
                            state_next = S_OP;
                        else
                        begin
                            st_next = ST_NO_FREE; use_next = 1'b0; ridx_next = '0;
                            state_next = S_COUNT;
                        end
                    end
                    else
                    begin
                        if (mask_fin == '0)
                        begin
                            st_next = ST_NONE_EV; use_next = 1'b0; ridx_next = '0;
                        end
                        else
                            ev_emit_next = 1'b1;
                        state_next = S_COUNT;
                    end
                end
                else
                    i_next = i_reg + IDX_W'(1);
            end

            // Single-slot operation on the addressed entry.
            S_OP:
            begin
                state_next = S_COUNT;
                i_next = '0;
                ridx_next = slot_reg;
                use_next = 1'b1;
                st_next = ST_OK;
                unique case (func_reg)
                    FN_ACQUIRE:
                    begin
                        ridx_next = 8'(found_reg);
                        new_ent.gen = ent.gen + 32'd1;
                        new_ent.phase = PH_PREFILL;
                        new_ent.owner = req_reg;
                        new_ent.access_time = now_reg;
                        new_ent.ready_time = '0;
                        new_ent.tok = '0;
                        wr_en = 1'b1;
                    end
                    FN_RELEASE, FN_MARK, FN_TOKENS, FN_READ:
                    begin
                        if (!slot_ok)
                        begin
                            st_next = ST_BAD_SLOT; use_next = 1'b0;
                        end
                        else
                        begin
                            wr_en = (func_reg != FN_READ);
                            if (func_reg == FN_RELEASE)
                            begin
                                new_ent.phase = PH_IDLE;
                                new_ent.owner = NONE_OWNER;
                                new_ent.tok = '0;
                                new_ent.ready_time = '0;
                            end
                            else if (func_reg == FN_MARK)
                            begin
                                new_ent.access_time = now_reg;
                                if (ent.phase == PH_PREFILL)
                                    new_ent.phase = PH_DECODE;
                            end
                            else
                                new_ent.tok = tokv_reg;
                        end
                    end
                    FN_RETIRE, FN_REL_LEASE, FN_COMPLETE, FN_LIVE:
                    begin
                        if (lgen_reg == '0)
                        begin
                            st_next = ST_REJECT; use_next = slot_ok;
                        end
                        else if (!slot_ok)
                        begin
                            st_next = ST_BAD_SLOT; use_next = 1'b0;
                        end
                        else if (func_reg == FN_LIVE)
                        begin
                            st_next = (ent.gen == lgen_reg && ent.owner == req_reg &&
                                       (ent.phase == PH_PREFILL || ent.phase == PH_DECODE))
                                      ? ST_OK : ST_REJECT;
                        end
                        else if (func_reg == FN_COMPLETE)
                        begin
                            if (ent.gen != lgen_reg || ent.phase != PH_RETIRE)
                                st_next = ST_REJECT;
                            else
                            begin
                                new_ent.phase = PH_IDLE;
                                new_ent.owner = NONE_OWNER;
                                new_ent.tok = '0;
                                new_ent.ready_time = '0;
                                wr_en = 1'b1;
                            end
                        end
                        else if (ent.gen != lgen_reg ||
                                 (ent.phase != PH_PREFILL && ent.phase != PH_DECODE &&
                                  ent.phase != PH_DONE))
                            st_next = ST_REJECT;
                        else
                        begin
                            new_ent.phase = PH_RETIRE;
                            new_ent.ready_time = (func_reg == FN_RETIRE) ? rdy_reg : now_reg;
                            new_ent.access_time = now_reg;
                            wr_en = 1'b1;
                            // An immediate release reaps every ready slot afterwards.
                            if (func_reg == FN_REL_LEASE)
                            begin
                                cnt_next = '0;
                                state_next = S_REAP;
                            end
                        end
                    end
                    FN_COUNTS:
                    begin
                        use_next = 1'b0; ridx_next = '0;
                    end
                    default:
                    begin
                        st_next = ST_REJECT; use_next = 1'b0; ridx_next = '0;
                    end
                endcase
            end

            // Phase census over the active slots.
            S_COUNT:
            begin
                if (ent.phase == PH_IDLE || ent.phase == PH_EVICT)
                    fr_next = fr_reg + CNT_W'(1);
                else if (ent.phase == PH_PREFILL || ent.phase == PH_DECODE)
                    us_next = us_reg + CNT_W'(1);
                else if (ent.phase == PH_RETIRE)
                    rt_next = rt_reg + CNT_W'(1);
                if (scan_end)
                begin
                    i_next = '0;
                    state_next = S_EMIT;
                end
                else
                    i_next = i_reg + IDX_W'(1);
            end

            // Load the result register; evict walks its mask for one beat per evicted slot.
            S_EMIT:
            begin
                o_fr_next = (func_reg == FN_REAP) ? cnt_reg : fr_reg;
                o_us_next = us_reg;
                o_rt_next = rt_reg;
                if (ev_emit_reg)
                begin
                    if (mask_reg[i_reg])
                    begin
                        mask_rest = mask_reg & ~(SLOTS'(1) << i_reg);
                        mask_next = mask_rest;
                        o_status_next = ST_OK;
                        o_idx_next = 8'(i_reg);
                        o_gen_next = ent.gen;
                        o_own_next = ent.owner;
                        o_ph_next = ent.phase;
                        o_tok_next = ent.tok;
                        o_last_next = (mask_rest == '0);
                        ov_next = 1'b1;
                        state_next = S_WAIT;
                    end
                    i_next = i_reg + IDX_W'(1);
                end
                else
                begin
                    o_status_next = st_reg;
                    o_idx_next = ridx_reg;
                    o_gen_next = use_reg ? ent.gen : '0;
                    o_own_next = use_reg ? ent.owner : NONE_OWNER;
                    o_ph_next = use_reg ? ent.phase : PH_IDLE;
                    o_tok_next = use_reg ? ent.tok : '0;
                    o_last_next = 1'b1;
                    ov_next = 1'b1;
                    state_next = S_WAIT;
                end
            end

            S_WAIT:
            begin
                if (out_ready)
                begin
                    ov_next = 1'b0;
                    state_next = o_last_reg ? S_IDLE : S_EMIT;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            timeout_reg <= TIMEOUT_RESET;
            active_reg <= ACTIVE_RESET;
            i_reg <= '0; found_reg <= '0; found_v_reg <= 1'b0; mask_reg <= '0;
            ev_emit_reg <= 1'b0; cnt_reg <= '0; fr_reg <= '0; us_reg <= '0;
            rt_reg <= '0; st_reg <= ST_OK; use_reg <= 1'b0; ridx_reg <= '0;
            ov_reg <= 1'b0; o_last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_fire)
            begin
                if (cfg_reg_t'(cfg_index) == REG_IDLE_TIMEOUT)
                    timeout_reg <= cfg_data;
                else
                    active_reg <= cfg_data[4:0];
            end
            i_reg <= i_next; found_reg <= found_next; found_v_reg <= found_v_next;
            mask_reg <= mask_next; ev_emit_reg <= ev_emit_next; cnt_reg <= cnt_next;
            fr_reg <= fr_next; us_reg <= us_next; rt_reg <= rt_next;
            st_reg <= st_next; use_reg <= use_next; ridx_reg <= ridx_next;
            ov_reg <= ov_next; o_last_reg <= o_last_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        func_reg <= func_next; slot_reg <= slot_next; req_reg <= req_next;
        lgen_reg <= lgen_next; now_reg <= now_next; rdy_reg <= rdy_next;
        tmo_reg <= tmo_next; tokv_reg <= tokv_next;
        o_status_reg <= o_status_next; o_idx_reg <= o_idx_next;
        o_gen_reg <= o_gen_next; o_own_reg <= o_own_next; o_ph_reg <= o_ph_next;
        o_tok_reg <= o_tok_next; o_fr_reg <= o_fr_next; o_us_reg <= o_us_next;
        o_rt_reg <= o_rt_next;
    end

    // Slot table: cleared by reset and by an active_slots write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SLOTS; k++)
            begin
                tbl_reg[k] <= '{phase: PH_IDLE, owner: NONE_OWNER, gen: '0,
                                tok: '0, access_time: '0, ready_time: '0};
            end
        end
        else if (cfg_fire && cfg_reg_t'(cfg_index) == REG_ACTIVE_SLOTS)
        begin
            for (int k = 0; k < SLOTS; k++)
            begin
                tbl_reg[k] <= '{phase: PH_IDLE, owner: NONE_OWNER, gen: '0,
                                tok: '0, access_time: '0, ready_time: '0};
            end
        end
        else if (wr_en)
        begin
            tbl_reg[rd_addr] <= new_ent;
        end
    end

    assign out_valid      = ov_reg;
    assign status         = o_status_reg;
    assign slot_index     = o_idx_reg;
    assign generation     = o_gen_reg;
    assign owner_request  = o_own_reg;
    assign phase          = o_ph_reg;
    assign tokens         = o_tok_reg;
    assign free_count     = o_fr_reg;
    assign used_count     = o_us_reg;
    assign retiring_count = o_rt_reg;
    assign last           = o_last_reg;

`ifndef NO_ASSERTIONS
    // A pending result beat keeps the input side closed.
    a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input accepted while a result is pending");

    // An accepted item always occupies the sequencer for the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("sequencer idle right after accepting an item");

    // The used and retiring counts together never exceed the active slot count.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (6'(used_count) + 6'(retiring_count) <= 6'(n_live)))
        else $error("phase census exceeds active slots");

    // A final beat that is taken returns the block to idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last) |=> cfg_ready)
        else $error("block not idle after final result");
`endif

endmodule

`default_nettype wire

>>> rtl/sslt_time_cmp.sv
// Shared time comparison unit: one modulo-2^32 subtract and one compare.
// Depends on sslt_pkg.
`default_nettype none

module sslt_time_cmp (
    input  wire logic [31:0]         now_time,
    input  wire logic [31:0]         stamp,
    input  wire logic [31:0]         limit,
    output sslt_pkg::time_flags_t    flags
);
    import sslt_pkg::*;

    logic [31:0] diff;

    // Elapsed ticks wrap modulo 2^32; the fence has passed when the
    // difference lies in the lower half of the circle.
    always_comb
    begin
        diff = now_time - stamp;
        flags.fence_passed = ~diff[31];
        flags.expired = (diff > limit);
    end

endmodule

`default_nettype wire
